### design/cubic_bspline_forward_diff_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cubic B-spline block. Clock is clock, reset is reset.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BSPLINE_FORWARD_DIFF_ASSERT_SVH
`define CUBIC_BSPLINE_FORWARD_DIFF_ASSERT_SVH

// same-cycle implication
`define CBFD_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CBFD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/cbfd_pkg.sv
// ----------------------------------------------------------------------------
// cbfd_pkg
// Shared types and constants of the cubic B-spline forward differencing block.
// ----------------------------------------------------------------------------
`default_nettype none

package cbfd_pkg;

   localparam int COORD_W     = 32;
   localparam int COEF_W      = 36;
   localparam int ACC_W       = 64;
   localparam int AXES        = 2;
   localparam int WIN_DEPTH   = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int DIV_LAT     = 3;

   localparam logic signed [COORD_W-1:0] OUT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] OUT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // four control points of one axis, p0 oldest
   typedef struct packed {
      logic signed [COORD_W-1:0] p0;
      logic signed [COORD_W-1:0] p1;
      logic signed [COORD_W-1:0] p2;
      logic signed [COORD_W-1:0] p3;
   } cbfd_axis_pts_type;

   // one complete segment request
   typedef struct packed {
      cbfd_axis_pts_type x;
      cbfd_axis_pts_type y;
   } cbfd_seg_type;

endpackage

`default_nettype wire

### design/cbfd_intf.sv
// ----------------------------------------------------------------------------
// cbfd_intf
// Valid/ready channels for control point requests and curve point responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbfd_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic               curve_start;

   modport source (output valid, output point_x, output point_y, output curve_start,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input curve_start,
                   output ready);
endinterface

interface cbfd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] curve_x;
   logic signed [31:0] curve_y;
   logic               segment_last;

   modport source (output valid, output curve_x, output curve_y, output segment_last,
                   input ready);
   modport sink   (input valid, input curve_x, input curve_y, input segment_last,
                   output ready);
endinterface

`default_nettype wire

### design/cbfd_front.sv
// ----------------------------------------------------------------------------
// cbfd_front
// Accepts control points, keeps the three-point window and pushes completed
// segments into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cbfd_front (
   input  logic                  clock,
   input  logic                  reset,
   cbfd_req_if.sink              req,
   output logic                  push,
   output cbfd_pkg::cbfd_seg_type push_data,
   input  logic                  q_full
);
   import cbfd_pkg::*;

   localparam logic [1:0] SEEN_MAX = 2'(WIN_DEPTH);

   logic signed [COORD_W-1:0] win_x_ff [WIN_DEPTH];
   logic signed [COORD_W-1:0] win_y_ff [WIN_DEPTH];
   logic signed [COORD_W-1:0] wx [WIN_DEPTH];
   logic signed [COORD_W-1:0] wy [WIN_DEPTH];
   logic [1:0]                seen_ff;
   logic [1:0]                seen_in;
   logic [1:0]                seen_eff;
   logic                      accept;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   // a new curve starts from an empty window
   always_comb begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         wx[i] = req.curve_start ? '0 : win_x_ff[i];
         wy[i] = req.curve_start ? '0 : win_y_ff[i];
      end
      seen_eff = req.curve_start ? 2'd0 : seen_ff;
      seen_in  = (seen_eff == SEEN_MAX) ? SEEN_MAX : seen_eff + 2'd1;
   end

   assign push = accept && (seen_eff == SEEN_MAX);

   always_comb begin
      push_data.x.p0 = wx[0];
      push_data.x.p1 = wx[1];
      push_data.x.p2 = wx[2];
      push_data.x.p3 = req.point_x;
      push_data.y.p0 = wy[0];
      push_data.y.p1 = wy[1];
      push_data.y.p2 = wy[2];
      push_data.y.p3 = req.point_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 2'd0;
      end else if (accept) begin
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            win_x_ff[i] <= wx[i+1];
            win_y_ff[i] <= wy[i+1];
         end
         win_x_ff[WIN_DEPTH-1] <= req.point_x;
         win_y_ff[WIN_DEPTH-1] <= req.point_y;
      end
   end

endmodule

`default_nettype wire

### design/cbfd_queue.sv
// ----------------------------------------------------------------------------
// cbfd_queue
// Short FIFO of segment requests between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cubic_bspline_forward_diff_assert.svh"

module cbfd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cbfd_pkg::cbfd_seg_type push_data,
   output logic                   full,
   output logic                   head_valid,
   output cbfd_pkg::cbfd_seg_type head_data,
   input  logic                   pop
);
   import cbfd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   cbfd_seg_type     mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `CBFD_ASSERT(a_no_overflow, push, !full, "queue push while full")
   `CBFD_ASSERT(a_no_underflow, pop, head_valid, "queue pop while empty")
   `CBFD_ASSERT(a_count_range, 1'b1, count_ff <= CNT_FULL, "queue count out of range")

endmodule

`default_nettype wire

### design/cbfd_div.sv
// ----------------------------------------------------------------------------
// cbfd_div
// Reciprocal-multiply divider: rounds a scaled accumulator value to the output
// format over three pipeline stages, with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module cbfd_div #(
   parameter int STEPS = 10
) (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic signed [cbfd_pkg::ACC_W-1:0]     num,
   output logic signed [cbfd_pkg::COORD_W-1:0]   quo
);
   import cbfd_pkg::*;

   localparam int DEN  = 6 * STEPS * STEPS * STEPS;
   localparam int RW   = $clog2(DEN);
   localparam int SH   = COORD_W + RW;
   localparam int PL_W = COORD_W + COORD_W + 1;
   localparam int PH_W = RW + COORD_W + 1;
   localparam int HS_W = PH_W + 1;
   localparam logic signed [ACC_W-1:0] LIM = ACC_W'(DEN) <<< COORD_W;
   localparam logic [ACC_W-1:0]        SCALE = ACC_W'(1) << SH;
   localparam logic [COORD_W:0]        RECIP = (COORD_W+1)'(SCALE / ACC_W'(DEN));
   localparam logic [RW:0]             DEN_C = (RW+1)'(DEN);

   logic [PL_W-1:0]    pl_ff;
   logic [PH_W-1:0]    ph_ff;
   logic [RW:0]        nlo1_ff;
   logic [RW:0]        nlo2_ff;
   logic               hi1_ff;
   logic               hi2_ff;
   logic               hi3_ff;
   logic               neg1_ff;
   logic               neg2_ff;
   logic               neg3_ff;
   logic [HS_W-1:0]    hs;
   logic [COORD_W-1:0] qh2_ff;
   logic [COORD_W-1:0] qh3_ff;
   logic [RW:0]        rem3_ff;
   logic               take;
   logic [COORD_W-1:0] qf;

   // num already carries the rounding and the 2^31 offset, so it is
   // nonnegative and below DEN * 2^32 unless the result saturates;
   // the scaled reciprocal gives the quotient or one less
   assign hs = HS_W'(pl_ff[PL_W-1:COORD_W]) + HS_W'(ph_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         pl_ff   <= PL_W'(num[COORD_W-1:0]) * PL_W'(RECIP);
         ph_ff   <= PH_W'(num[COORD_W +: RW]) * PH_W'(RECIP);
         nlo1_ff <= num[RW:0];
         hi1_ff  <= (num >= LIM);
         neg1_ff <= (num < 0);

         qh2_ff  <= hs[RW +: COORD_W];
         nlo2_ff <= nlo1_ff;
         hi2_ff  <= hi1_ff;
         neg2_ff <= neg1_ff;

         rem3_ff <= nlo2_ff - qh2_ff[RW:0] * DEN_C;
         qh3_ff  <= qh2_ff;
         hi3_ff  <= hi2_ff;
         neg3_ff <= neg2_ff;
      end
   end

   assign take = (rem3_ff >= DEN_C);
   assign qf   = qh3_ff + COORD_W'(take);

   always_comb begin
      if (hi3_ff) begin
         quo = OUT_MAX;
      end else if (neg3_ff) begin
         quo = OUT_MIN;
      end else begin
         quo = {~qf[COORD_W-1], qf[COORD_W-2:0]};
      end
   end

endmodule

`default_nettype wire

### design/cbfd_back.sv
// ----------------------------------------------------------------------------
// cbfd_back
// Segment engine: basis matrix coefficients, forward difference setup, one
// curve point per cycle into the divider pipelines (held while the response
// register stalls), response register.
`default_nettype none

`include "cubic_bspline_forward_diff_assert.svh"

module cbfd_back #(
   parameter int STEPS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  cbfd_pkg::cbfd_seg_type q_data,
   output logic                   q_pop,
   cbfd_rsp_if.source             rsp
);
   import cbfd_pkg::*;

   localparam int S2   = STEPS * STEPS;
   localparam int S3   = S2 * STEPS;
   localparam int DEN  = 6 * S3;
   localparam int K1_W = $clog2(STEPS + 1) + 1;
   localparam int K2_W = $clog2(S2 + 1) + 1;
   localparam int K3_W = $clog2(S3 + 1) + 1;
   localparam int PB_W = COEF_W + K1_W;
   localparam int PC_W = COEF_W + K2_W;
   localparam int PD_W = COEF_W + K3_W;
   localparam int A6_W = COEF_W + 3;
   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   localparam logic signed [K1_W-1:0] K1 = K1_W'(STEPS);
   localparam logic signed [K2_W-1:0] K2 = K2_W'(S2);
   localparam logic signed [K3_W-1:0] K3 = K3_W'(S3);
   localparam logic [CNT_W-1:0]       LAST_STEP = CNT_W'(STEPS - 1);
   // round half up plus the offset that keeps the divider input nonnegative
   localparam logic signed [ACC_W-1:0] F0_BIAS =
      ACC_W'(DEN / 2) + (ACC_W'(DEN) <<< (COORD_W - 1));

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_SUM, ST_RUN} state_type;

   state_type          state_ff;
   state_type          state_in;
   logic [CNT_W-1:0]   step_ff;
   logic [CNT_W-1:0]   step_in;
   logic [DIV_LAT-1:0] vld_pipe_ff;
   logic [DIV_LAT-1:0] vld_pipe_in;
   logic [DIV_LAT-1:0] last_pipe_ff;
   logic [DIV_LAT-1:0] last_pipe_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic signed [COORD_W-1:0] rsp_x_ff;
   logic signed [COORD_W-1:0] rsp_y_ff;
   logic               rsp_last_ff;
   logic               en;
   logic               issue;

   cbfd_axis_pts_type         pts [AXES];
   logic signed [COEF_W-1:0]  p0e [AXES];
   logic signed [COEF_W-1:0]  p1e [AXES];
   logic signed [COEF_W-1:0]  p2e [AXES];
   logic signed [COEF_W-1:0]  p3e [AXES];
   logic signed [COEF_W-1:0]  a_in [AXES];
   logic signed [COEF_W-1:0]  b_in [AXES];
   logic signed [COEF_W-1:0]  c_in [AXES];
   logic signed [COEF_W-1:0]  d_in [AXES];
   logic signed [COEF_W-1:0]  a_ff [AXES];
   logic signed [COEF_W-1:0]  b_ff [AXES];
   logic signed [COEF_W-1:0]  c_ff [AXES];
   logic signed [COEF_W-1:0]  d_ff [AXES];
   logic signed [PB_W-1:0]    pb_ff [AXES];
   logic signed [PC_W-1:0]    pc_ff [AXES];
   logic signed [PD_W-1:0]    pd_ff [AXES];
   logic signed [A6_W-1:0]    a6_ff [AXES];
   logic signed [ACC_W-1:0]   f0_ff [AXES];
   logic signed [ACC_W-1:0]   f1_ff [AXES];
   logic signed [ACC_W-1:0]   f2_ff [AXES];
   logic signed [ACC_W-1:0]   f3_ff [AXES];
   logic signed [ACC_W-1:0]   f0_in [AXES];
   logic signed [ACC_W-1:0]   f1_in [AXES];
   logic signed [ACC_W-1:0]   f2_in [AXES];
   logic signed [ACC_W-1:0]   f3_in [AXES];
   logic signed [COORD_W-1:0] quo [AXES];

   assign en = !rsp_valid_ff || rsp.ready;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.curve_x      = rsp_x_ff;
   assign rsp.curve_y      = rsp_y_ff;
   assign rsp.segment_last = rsp_last_ff;

   // -------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      q_pop    = 1'b0;
      issue    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_RUN;
            step_in  = '0;
         end
         ST_RUN: begin
            if (en) begin
               issue = 1'b1;
               if (step_ff == LAST_STEP) begin
                  state_in = ST_IDLE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      vld_pipe_in  = vld_pipe_ff;
      last_pipe_in = last_pipe_ff;
      rsp_valid_in = rsp_valid_ff;
      if (en) begin
         vld_pipe_in  = {vld_pipe_ff[DIV_LAT-2:0], issue};
         last_pipe_in = {last_pipe_ff[DIV_LAT-2:0], issue && (step_ff == LAST_STEP)};
         rsp_valid_in = vld_pipe_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         vld_pipe_ff  <= '0;
         last_pipe_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         vld_pipe_ff  <= vld_pipe_in;
         last_pipe_ff <= last_pipe_in;
         rsp_valid_ff <= rsp_valid_in;
         if (en) begin
            rsp_x_ff    <= quo[0];
            rsp_y_ff    <= quo[1];
            rsp_last_ff <= last_pipe_ff[DIV_LAT-1];
         end
      end
   end

   // -------------------------------------------------------------- datapath
   assign pts[0] = q_data.x;
   assign pts[1] = q_data.y;

   // basis matrix times 6: integer coefficients
   always_comb begin
      for (int ax = 0; ax < AXES; ax++) begin
         p0e[ax]  = COEF_W'(pts[ax].p0);
         p1e[ax]  = COEF_W'(pts[ax].p1);
         p2e[ax]  = COEF_W'(pts[ax].p2);
         p3e[ax]  = COEF_W'(pts[ax].p3);
         a_in[ax] = p3e[ax] - p0e[ax] + (p1e[ax] + (p1e[ax] <<< 1))
                    - (p2e[ax] + (p2e[ax] <<< 1));
         b_in[ax] = (p0e[ax] + (p0e[ax] <<< 1)) - (p1e[ax] <<< 2) - (p1e[ax] <<< 1)
                    + (p2e[ax] + (p2e[ax] <<< 1));
         c_in[ax] = (p2e[ax] + (p2e[ax] <<< 1)) - (p0e[ax] + (p0e[ax] <<< 1));
         d_in[ax] = p0e[ax] + (p1e[ax] <<< 2) + p2e[ax];
      end
   end

   always_comb begin
      for (int ax = 0; ax < AXES; ax++) begin
         f0_in[ax] = f0_ff[ax];
         f1_in[ax] = f1_ff[ax];
         f2_in[ax] = f2_ff[ax];
         f3_in[ax] = f3_ff[ax];
         if (state_ff == ST_SUM) begin
            f0_in[ax] = ACC_W'(pd_ff[ax]) + F0_BIAS;
            f1_in[ax] = ACC_W'(a_ff[ax]) + ACC_W'(pb_ff[ax]) + ACC_W'(pc_ff[ax]);
            f2_in[ax] = ACC_W'(a6_ff[ax]) + (ACC_W'(pb_ff[ax]) <<< 1);
            f3_in[ax] = ACC_W'(a6_ff[ax]);
         end else if (issue) begin
            f0_in[ax] = f0_ff[ax] + f1_ff[ax];
            f1_in[ax] = f1_ff[ax] + f2_ff[ax];
            f2_in[ax] = f2_ff[ax] + f3_ff[ax];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int ax = 0; ax < AXES; ax++) begin
         if (q_pop) begin
            a_ff[ax] <= a_in[ax];
            b_ff[ax] <= b_in[ax];
            c_ff[ax] <= c_in[ax];
            d_ff[ax] <= d_in[ax];
         end
         if (state_ff == ST_MUL) begin
            pb_ff[ax] <= b_ff[ax] * K1;
            pc_ff[ax] <= c_ff[ax] * K2;
            pd_ff[ax] <= d_ff[ax] * K3;
            a6_ff[ax] <= (A6_W'(a_ff[ax]) <<< 2) + (A6_W'(a_ff[ax]) <<< 1);
         end
         f0_ff[ax] <= f0_in[ax];
         f1_ff[ax] <= f1_in[ax];
         f2_ff[ax] <= f2_in[ax];
         f3_ff[ax] <= f3_in[ax];
      end
   end

   for (genvar ax = 0; ax < AXES; ax++) begin : g_axis
      cbfd_div #(
         .STEPS (STEPS)
      ) u_div (
         .clock (clock),
         .en    (en),
         .num   (f0_ff[ax]),
         .quo   (quo[ax])
      );
   end

   `CBFD_ASSERT(a_step_range, state_ff == ST_RUN, step_ff <= LAST_STEP,
      "step counter beyond segment length")
   `CBFD_ASSERT_NEXT(a_run_exit, issue && (step_ff == LAST_STEP), state_ff == ST_IDLE,
      "sequencer did not leave run after last step")
   `CBFD_ASSERT(a_last_tagged, 1'b1, (last_pipe_ff & ~vld_pipe_ff) == '0,
      "segment end tag without a valid point")

endmodule

`default_nettype wire

### design/cubic_bspline_forward_diff.sv
// ----------------------------------------------------------------------------
// cubic_bspline_forward_diff: STEPS curve points per segment, one per cycle
// while rsp_ch is ready. The back-end sequencer pops a segment, then scales the
// coefficients, sets up the differences, issues the points, then pops the next.
// Synchronous reset clears point count, queue, sequencer, pipeline valids only.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bspline_forward_diff #(
   parameter int STEPS = 10
) (
   input  logic       clock,
   input  logic       reset,
   cbfd_req_if.sink   req_ch,
   cbfd_rsp_if.source rsp_ch
);
   import cbfd_pkg::*;

   logic         push;
   cbfd_seg_type push_data;
   logic         q_full;
   logic         q_valid;
   cbfd_seg_type q_data;
   logic         q_pop;

   cbfd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full)
   );

   cbfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (q_full),
      .head_valid (q_valid),
      .head_data  (q_data),
      .pop        (q_pop)
   );

   cbfd_back #(
      .STEPS (STEPS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_data  (q_data),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );

endmodule

`default_nettype wire
